### rtl/cllm_pkg.sv
// shared types and constants for the cursor linked list manager
// no dependencies
package cllm_pkg;

  localparam int NODES_DEF    = 16;
  localparam int KEY_BITS_DEF = 64;
  localparam int POS_W        = 5;
  localparam int KEY_W        = 64;
  localparam int FUNC_W       = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_FREE,
    S_INS_WALK,
    S_INS_LINK,
    S_DEL_HEAD,
    S_DEL_WALK,
    S_DEL_NEXT,
    S_DEL_FREE,
    S_SRCH,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic link_we;
    logic key_we;
  } mem_wr_t;

endpackage

### rtl/cursor_linked_list_manager_unit.sv
// Cursor linked list manager: array-backed singly linked list with a free
// chain of NODES entries. Each request on the input channel (func,
// position, key) inserts a key at a 1-based position, deletes the entry at
// a position, or searches for a key. One result per request leaves on the
// output channel (status, found_position, entry_count).
// Both channels use valid/ready; a request is taken when in_valid and
// in_ready are high at a clock edge, a result when out_valid and out_ready
// are high.
// The link memory's single read port walks one link per cycle, and one
// request is worked at a time; the next request is taken once the current
// result has moved into the output register.
// Reset (rst, synchronous) empties the list and restores the free chain
// through all entries at once; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register, the
// sequencer holds its next result, and in_ready stays low meanwhile.
// uses cllm_pkg, cllm_seq, cllm_store, cllm_step
module cursor_linked_list_manager_unit #(
  parameter int NODES    = cllm_pkg::NODES_DEF,
  parameter int KEY_BITS = cllm_pkg::KEY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cllm_pkg::FUNC_W-1:0] func,
  input  logic [cllm_pkg::POS_W-1:0]  position,
  input  logic [cllm_pkg::KEY_W-1:0]  key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [cllm_pkg::POS_W-1:0]  found_position,
  output logic [cllm_pkg::POS_W-1:0]  entry_count
);

  localparam int IW = $clog2(NODES + 1);
  localparam int AW = $clog2(NODES);

  logic                       res_valid;
  logic                       res_ready;
  cllm_pkg::status_t          res_status;
  logic [cllm_pkg::POS_W-1:0] res_found;
  logic [cllm_pkg::POS_W-1:0] res_count;
  logic [AW-1:0]              rd_addr;
  logic [IW-1:0]              link_rd;
  logic [KEY_BITS-1:0]        key_rd;
  cllm_pkg::mem_wr_t          mem_wr;
  logic [AW-1:0]              link_wa;
  logic [IW-1:0]              link_wd;
  logic [AW-1:0]              key_wa;
  logic [KEY_BITS-1:0]        key_wd;
  cllm_pkg::status_t          out_status;

  cllm_store #(
    .NODES    (NODES),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .link_rd (link_rd),
    .key_rd  (key_rd),
    .mem_wr  (mem_wr),
    .link_wa (link_wa),
    .link_wd (link_wd),
    .key_wa  (key_wa),
    .key_wd  (key_wd)
  );

  cllm_seq #(
    .NODES    (NODES),
    .KEY_BITS (KEY_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .position   (position),
    .key        (key),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_status (res_status),
    .res_found  (res_found),
    .res_count  (res_count),
    .rd_addr    (rd_addr),
    .link_rd    (link_rd),
    .key_rd     (key_rd),
    .mem_wr     (mem_wr),
    .link_wa    (link_wa),
    .link_wd    (link_wd),
    .key_wa     (key_wa),
    .key_wd     (key_wd)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status     <= res_status;
      found_position <= res_found;
      entry_count    <= res_count;
    end
  end

  assign status = out_status;

endmodule

### rtl/cllm_step.sv
// shared walk unit: sanitized link follow and key compare for one entry
// depends on nothing but its parameters
module cllm_step #(
  parameter int NODES    = 16,
  parameter int KEY_BITS = 64,
  localparam int IW      = $clog2(NODES + 1)
) (
  input  logic [IW-1:0]       last_idx,
  input  logic [IW-1:0]       link_rd,
  input  logic [KEY_BITS-1:0] key_rd,
  input  logic [KEY_BITS-1:0] key_ref,
  output logic [IW-1:0]       follow,
  output logic                key_hit
);

  localparam logic [IW-1:0] NIL = IW'(NODES);

  always_comb begin
    if (last_idx >= NIL) begin
      follow = NIL;
    end else if (link_rd < NIL) begin
      follow = link_rd;
    end else begin
      follow = NIL;
    end
  end

  assign key_hit = (key_rd == key_ref);

endmodule

### rtl/cllm_store.sv
// key and link memories with registered reads; link entries not yet
// written read as the initial free chain. uses cllm_pkg
module cllm_store #(
  parameter int NODES    = 16,
  parameter int KEY_BITS = 64,
  localparam int IW      = $clog2(NODES + 1),
  localparam int AW      = $clog2(NODES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [AW-1:0]       rd_addr,
  output logic [IW-1:0]       link_rd,
  output logic [KEY_BITS-1:0] key_rd,
  input  cllm_pkg::mem_wr_t   mem_wr,
  input  logic [AW-1:0]       link_wa,
  input  logic [IW-1:0]       link_wd,
  input  logic [AW-1:0]       key_wa,
  input  logic [KEY_BITS-1:0] key_wd
);

  logic [KEY_BITS-1:0] key_mem [NODES];
  logic [IW-1:0]       link_mem [NODES];
  logic [NODES-1:0]    vld;
  logic [IW-1:0]       link_q;
  logic                vld_q;
  logic [AW-1:0]       addr_q;

  always_ff @(posedge clk) begin
    if (mem_wr.key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    key_rd <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_wr.link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_q <= link_mem[rd_addr];
    addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld[rd_addr];
      if (mem_wr.link_we) begin
        vld[link_wa] <= 1'b1;
      end
    end
  end

  // unwritten entry links to the next index
  assign link_rd = vld_q ? link_q : (IW'(addr_q) + IW'(1));

endmodule

### rtl/cllm_seq.sv
// sequencer for insert, delete and search; walks one link per cycle
// through the shared step unit. uses cllm_pkg and cllm_step
module cllm_seq #(
  parameter int NODES    = 16,
  parameter int KEY_BITS = 64,
  localparam int IW      = $clog2(NODES + 1),
  localparam int AW      = $clog2(NODES)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cllm_pkg::FUNC_W-1:0] func,
  input  logic [cllm_pkg::POS_W-1:0]  position,
  input  logic [cllm_pkg::KEY_W-1:0]  key,
  output logic                        res_valid,
  input  logic                        res_ready,
  output cllm_pkg::status_t           res_status,
  output logic [cllm_pkg::POS_W-1:0]  res_found,
  output logic [cllm_pkg::POS_W-1:0]  res_count,
  output logic [AW-1:0]               rd_addr,
  input  logic [IW-1:0]               link_rd,
  input  logic [KEY_BITS-1:0]         key_rd,
  output cllm_pkg::mem_wr_t           mem_wr,
  output logic [AW-1:0]               link_wa,
  output logic [IW-1:0]               link_wd,
  output logic [AW-1:0]               key_wa,
  output logic [KEY_BITS-1:0]         key_wd
);

  localparam int CW = $clog2(NODES + 2);
  localparam int PW = ((IW > cllm_pkg::POS_W) ? IW : cllm_pkg::POS_W) + 1;
  localparam logic [IW-1:0] NIL = IW'(NODES);

  cllm_pkg::state_t state, state_next;
  cllm_pkg::status_t status_r, status_next;

  logic [cllm_pkg::FUNC_W-1:0] func_r;
  logic [cllm_pkg::POS_W-1:0]  pos_r;
  logic [KEY_BITS-1:0]         key_r;
  logic [IW-1:0] head, head_next;
  logic [IW-1:0] free_head, free_head_next;
  logic [IW-1:0] len, len_next;
  logic [IW-1:0] cur, cur_next;
  logic [IW-1:0] prev, prev_next;
  logic [IW-1:0] node, node_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] found, found_next;
  logic [IW-1:0] follow;
  logic          key_hit;
  logic [PW-1:0] pos_x, len_x;
  logic          ins_bad, del_bad, full, pos_one;

  cllm_step #(
    .NODES    (NODES),
    .KEY_BITS (KEY_BITS)
  ) u_step (
    .last_idx (cur),
    .link_rd  (link_rd),
    .key_rd   (key_rd),
    .key_ref  (key_r),
    .follow   (follow),
    .key_hit  (key_hit)
  );

  assign pos_x   = PW'(pos_r);
  assign len_x   = PW'(len);
  assign ins_bad = (pos_x == '0) || (pos_x > len_x + PW'(1));
  assign del_bad = (pos_x == '0) || (pos_x > len_x);
  assign full    = (free_head >= NIL) || (len >= NIL);
  assign pos_one = (pos_x == PW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cllm_pkg::S_IDLE;
      head      <= NIL;
      free_head <= '0;
      len       <= '0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      free_head <= free_head_next;
      len       <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= func;
      pos_r  <= position;
      key_r  <= key[KEY_BITS-1:0];
    end
    cur      <= cur_next;
    prev     <= prev_next;
    node     <= node_next;
    cnt      <= cnt_next;
    found    <= found_next;
    status_r <= status_next;
  end

  always_comb begin
    state_next     = state;
    head_next      = head;
    free_head_next = free_head;
    len_next       = len;
    prev_next      = prev;
    node_next      = node;
    cnt_next       = cnt;
    found_next     = found;
    status_next    = status_r;
    cur_next       = cur;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    mem_wr         = '0;
    link_wa        = prev[AW-1:0];
    link_wd        = node;
    key_wa         = node[AW-1:0];
    key_wd         = key_r;
    unique case (state)
      cllm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = cllm_pkg::S_DISPATCH;
        end
      end
      cllm_pkg::S_DISPATCH: begin
        found_next  = '0;
        status_next = cllm_pkg::ST_OK;
        unique case (func_r)
          cllm_pkg::FUNC_INSERT: begin
            if (ins_bad) begin
              status_next = cllm_pkg::ST_BAD_POS;
              state_next  = cllm_pkg::S_RESULT;
            end else if (full) begin
              status_next = cllm_pkg::ST_FULL;
              state_next  = cllm_pkg::S_RESULT;
            end else begin
              node_next  = free_head;
              cur_next   = free_head;
              state_next = cllm_pkg::S_INS_FREE;
            end
          end
          cllm_pkg::FUNC_DELETE: begin
            if (del_bad) begin
              status_next = cllm_pkg::ST_BAD_POS;
              state_next  = cllm_pkg::S_RESULT;
            end else if (pos_one) begin
              node_next  = head;
              cur_next   = head;
              state_next = cllm_pkg::S_DEL_HEAD;
            end else begin
              cur_next   = head;
              cnt_next   = CW'(pos_x - PW'(2));
              state_next = cllm_pkg::S_DEL_WALK;
            end
          end
          cllm_pkg::FUNC_SEARCH: begin
            cur_next   = head;
            cnt_next   = CW'(1);
            state_next = cllm_pkg::S_SRCH;
          end
          default: begin
            state_next = cllm_pkg::S_RESULT;
          end
        endcase
      end
      cllm_pkg::S_INS_FREE: begin
        free_head_next = follow;
        mem_wr.key_we  = 1'b1;
        if (pos_one) begin
          mem_wr.link_we = 1'b1;
          link_wa        = node[AW-1:0];
          link_wd        = head;
          head_next      = node;
          len_next       = len + IW'(1);
          state_next     = cllm_pkg::S_RESULT;
        end else begin
          cur_next   = head;
          cnt_next   = CW'(pos_x - PW'(2));
          state_next = cllm_pkg::S_INS_WALK;
        end
      end
      cllm_pkg::S_INS_WALK: begin
        if (cnt == '0) begin
          prev_next      = cur;
          mem_wr.link_we = 1'b1;
          link_wa        = node[AW-1:0];
          link_wd        = follow;
          state_next     = cllm_pkg::S_INS_LINK;
        end else begin
          cur_next = follow;
          cnt_next = cnt - CW'(1);
        end
      end
      cllm_pkg::S_INS_LINK: begin
        mem_wr.link_we = (prev < NIL);
        len_next       = len + IW'(1);
        state_next     = cllm_pkg::S_RESULT;
      end
      cllm_pkg::S_DEL_HEAD: begin
        head_next = follow;
        if (node < NIL) begin
          mem_wr.link_we = 1'b1;
          link_wa        = node[AW-1:0];
          link_wd        = free_head;
          free_head_next = node;
        end
        len_next   = len - IW'(1);
        state_next = cllm_pkg::S_RESULT;
      end
      cllm_pkg::S_DEL_WALK: begin
        if (cnt == '0) begin
          prev_next  = cur;
          node_next  = follow;
          cur_next   = follow;
          state_next = cllm_pkg::S_DEL_NEXT;
        end else begin
          cur_next = follow;
          cnt_next = cnt - CW'(1);
        end
      end
      cllm_pkg::S_DEL_NEXT: begin
        mem_wr.link_we = (prev < NIL);
        link_wd        = follow;
        state_next     = cllm_pkg::S_DEL_FREE;
      end
      cllm_pkg::S_DEL_FREE: begin
        if (node < NIL) begin
          mem_wr.link_we = 1'b1;
          link_wa        = node[AW-1:0];
          link_wd        = free_head;
          free_head_next = node;
        end
        len_next   = len - IW'(1);
        state_next = cllm_pkg::S_RESULT;
      end
      cllm_pkg::S_SRCH: begin
        if ((cur >= NIL) || (cnt > CW'(len))) begin
          status_next = cllm_pkg::ST_NOT_FOUND;
          state_next  = cllm_pkg::S_RESULT;
        end else if (key_hit) begin
          found_next = cnt;
          state_next = cllm_pkg::S_RESULT;
        end else begin
          cur_next = follow;
          cnt_next = cnt + CW'(1);
        end
      end
      cllm_pkg::S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = cllm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cllm_pkg::S_IDLE;
      end
    endcase
  end

  assign rd_addr    = cur_next[AW-1:0];
  assign res_status = status_r;
  assign res_found  = cllm_pkg::POS_W'(found);
  assign res_count  = cllm_pkg::POS_W'(len);

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= NIL)
    else $error("list length above store depth");

  a_free_empty_full: assert property (@(posedge clk) disable iff (rst)
    (state == cllm_pkg::S_IDLE) |-> ((free_head >= NIL) == (len == NIL)))
    else $error("free chain and list length disagree");

  a_head_empty: assert property (@(posedge clk) disable iff (rst)
    (state == cllm_pkg::S_IDLE) |-> ((head >= NIL) == (len == '0)))
    else $error("head link and list length disagree");

  a_key_write_node: assert property (@(posedge clk) disable iff (rst)
    mem_wr.key_we |-> (node < NIL))
    else $error("key write to null entry");

endmodule

### tb/sv/tb_cursor_linked_list_manager_unit.sv
// self-checking testbench for cursor_linked_list_manager_unit: directed and random
// insert, delete and search requests checked against a queue-based list predictor
// depends on cllm_pkg and the unit under test
module tb_cursor_linked_list_manager_unit;

  localparam logic [cllm_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int DEPTH       = cllm_pkg::NODES_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    cllm_pkg::status_t          st;
    logic [cllm_pkg::POS_W-1:0] found;
    logic [cllm_pkg::POS_W-1:0] count;
  } list_result_t;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        in_valid  = 1'b0;
  logic [cllm_pkg::FUNC_W-1:0] func      = cllm_pkg::FUNC_INSERT;
  logic [cllm_pkg::POS_W-1:0]  position  = '0;
  logic [cllm_pkg::KEY_W-1:0]  key       = '0;
  logic                        out_ready = 1'b0;
  logic                        in_ready;
  logic                        out_valid;
  logic [1:0]                  status;
  logic [cllm_pkg::POS_W-1:0]  found_position;
  logic [cllm_pkg::POS_W-1:0]  entry_count;

  logic [cllm_pkg::KEY_W-1:0] list_keys[$];
  list_result_t               awaited_results[$];
  int                         errors    = 0;
  int                         requests  = 0;
  int                         checked   = 0;
  int                         full_hits = 0;
  int                         cycles    = 0;
  bit                         idle_on   = 1'b1;
  bit                         hold_req  = 1'b0;

  cursor_linked_list_manager_unit uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .position       (position),
    .key            (key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

  always #5 clk = ~clk;

  function automatic list_result_t list_outcome(input logic [cllm_pkg::FUNC_W-1:0] f,
                                                input logic [cllm_pkg::POS_W-1:0] p,
                                                input logic [cllm_pkg::KEY_W-1:0] k);
    list_result_t r;
    int n;
    r.st    = cllm_pkg::ST_OK;
    r.found = '0;
    n       = list_keys.size();
    case (f)
      cllm_pkg::FUNC_INSERT: begin
        if (p == 0 || p > n + 1) r.st = cllm_pkg::ST_BAD_POS;
        else if (n >= DEPTH) r.st = cllm_pkg::ST_FULL;
        else list_keys.insert(p - 1, k);
      end
      cllm_pkg::FUNC_DELETE: begin
        if (p == 0 || p > n) r.st = cllm_pkg::ST_BAD_POS;
        else list_keys.delete(p - 1);
      end
      cllm_pkg::FUNC_SEARCH: begin
        r.st = cllm_pkg::ST_NOT_FOUND;
        for (int i = 0; i < n; i++) begin
          if (list_keys[i] == k) begin
            r.st    = cllm_pkg::ST_OK;
            r.found = cllm_pkg::POS_W'(i + 1);
            break;
          end
        end
      end
      default: ;
    endcase
    r.count = cllm_pkg::POS_W'(list_keys.size());
    return r;
  endfunction

  function automatic logic [cllm_pkg::KEY_W-1:0] rand_key();
    if ($urandom_range(0, 3) == 0) return cllm_pkg::KEY_W'($urandom_range(0, 7));
    return {$urandom, $urandom};
  endfunction

  task automatic send_request(input logic [cllm_pkg::FUNC_W-1:0] f,
                              input logic [cllm_pkg::POS_W-1:0] p,
                              input logic [cllm_pkg::KEY_W-1:0] k);
    list_result_t r;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    position <= p;
    key      <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = list_outcome(f, p, k);
    if (r.st == cllm_pkg::ST_FULL) full_hits++;
    awaited_results.push_back(r);
    requests++;
  endtask

  task automatic send_noise();
    int n;
    n = list_keys.size();
    case ($urandom_range(0, 2))
      0: send_request(cllm_pkg::FUNC_INSERT,
                      cllm_pkg::POS_W'(($urandom_range(0, 3) == 0) ? 0 :
                                       $urandom_range(n + 2, 31)), rand_key());
      1: send_request(cllm_pkg::FUNC_DELETE,
                      cllm_pkg::POS_W'(($urandom_range(0, 3) == 0) ? 0 :
                                       $urandom_range(n + 1, 31)), rand_key());
      default: send_request(FUNC_NONE, cllm_pkg::POS_W'($urandom), rand_key());
    endcase
  endtask

  task automatic test_basic();
    send_request(cllm_pkg::FUNC_SEARCH, 5'd1, '0);
    send_request(cllm_pkg::FUNC_DELETE, 5'd1, '0);
    send_request(cllm_pkg::FUNC_INSERT, 5'd0, '1);
    send_request(cllm_pkg::FUNC_INSERT, 5'd2, '1);
    send_request(cllm_pkg::FUNC_INSERT, 5'd1, '0);
    send_request(cllm_pkg::FUNC_INSERT, 5'd2, '1);
    send_request(cllm_pkg::FUNC_INSERT, 5'd2, 64'h0123_4567_89ab_cdef);
    send_request(cllm_pkg::FUNC_INSERT, 5'd31, 64'h5555_5555_5555_5555);
    send_request(cllm_pkg::FUNC_INSERT, 5'd4, 64'h8000_0000_0000_0000);
    send_request(cllm_pkg::FUNC_SEARCH, 5'd31, '1);
    send_request(cllm_pkg::FUNC_SEARCH, 5'd0, 64'h1);
    send_request(FUNC_NONE, 5'd31, '1);
    send_request(cllm_pkg::FUNC_DELETE, 5'd0, '0);
    send_request(cllm_pkg::FUNC_DELETE, 5'd5, '0);
    send_request(cllm_pkg::FUNC_DELETE, 5'd2, '0);
    send_request(cllm_pkg::FUNC_DELETE, 5'd3, '0);
    send_request(cllm_pkg::FUNC_DELETE, 5'd1, '0);
    send_request(cllm_pkg::FUNC_SEARCH, 5'd16, '1);
    send_request(cllm_pkg::FUNC_SEARCH, 5'd0, 64'h0123_4567_89ab_cdef);
    send_request(cllm_pkg::FUNC_DELETE, 5'd1, 64'haaaa_aaaa_aaaa_aaaa);
  endtask

  task automatic test_full_store();
    while (list_keys.size() < DEPTH)
      send_request(cllm_pkg::FUNC_INSERT,
                   cllm_pkg::POS_W'($urandom_range(1, list_keys.size() + 1)), rand_key());
    send_request(cllm_pkg::FUNC_INSERT, 5'd17, rand_key());
    send_request(cllm_pkg::FUNC_INSERT, 5'd1, rand_key());
    send_request(cllm_pkg::FUNC_INSERT, 5'd18, rand_key());
    send_request(cllm_pkg::FUNC_SEARCH, 5'd0, list_keys[DEPTH-1]);
    send_request(cllm_pkg::FUNC_DELETE, 5'd16, '0);
    send_request(cllm_pkg::FUNC_DELETE, 5'd16, '0);
  endtask

  task automatic test_random(input int count);
    bit growing;
    int n;
    int r;
    growing = 1'b1;
    repeat (count) begin
      n = list_keys.size();
      if (n == DEPTH) growing = 1'b0;
      else if (n == 0) growing = 1'b1;
      else if ($urandom_range(0, 49) == 0) growing = !growing;
      r = $urandom_range(0, 99);
      if (r < 8)
        send_noise();
      else if (r < (growing ? 55 : 25))
        send_request(cllm_pkg::FUNC_INSERT, cllm_pkg::POS_W'($urandom_range(1, n + 1)),
                     rand_key());
      else if (r < 75 && n > 0)
        send_request(cllm_pkg::FUNC_DELETE, cllm_pkg::POS_W'($urandom_range(1, n)),
                     rand_key());
      else if (n > 0 && $urandom_range(0, 2) != 0)
        send_request(cllm_pkg::FUNC_SEARCH, cllm_pkg::POS_W'($urandom),
                     list_keys[$urandom_range(0, n - 1)]);
      else
        send_request(cllm_pkg::FUNC_SEARCH, cllm_pkg::POS_W'($urandom), rand_key());
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    test_random(24);
  endtask

  // receiver: random stalls, plus one long hold when requested
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d found_position=%0d entry_count=%0d",
                 $time, status, found_position, entry_count);
      end else begin
        want = awaited_results.pop_front();
        checked++;
        if (status !== want.st) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
        end
        if (found_position !== want.found) begin
          errors++;
          $display("%0t: found_position expected %0d actual %0d",
                   $time, want.found, found_position);
        end
        if (entry_count !== want.count) begin
          errors++;
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count, entry_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
      $display("tb_cursor_linked_list_manager_unit: errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic();
    test_full_store();
    test_backpressure();
    test_random(1450);
    idle_on = 1'b0;
    test_random(120);
    in_valid <= 1'b0;
    wait (awaited_results.size() == 0);
    repeat (40) @(posedge clk);
    $display("run covered %0d requests and %0d checked results, store full reported %0d times",
             requests, checked, full_hits);
    if (errors == 0) begin
      $display("tb_cursor_linked_list_manager_unit: clean");
    end else begin
      $display("tb_cursor_linked_list_manager_unit: errors");
    end
    $finish;
  end

endmodule
